### src/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// shared types and constants of the bilinear bayer demosaic unit
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CFG_W     = 12;
  localparam int ROW_W     = 12;
  localparam int PIX_W     = 8;
  localparam int OUT_COL_W = 11;
  localparam int CMP_W     = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
  localparam int MAX_W_CFG = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
  localparam int MIN_SIZE  = 3;

  localparam int OUT_DATA_W = 3 * PIX_W + OUT_COL_W + ROW_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_e;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_word_t;

  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             done;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } bbd_ctrl_t;

endpackage

### src/bbd_line_store.sv
// ----------------------------------------------------------------------------
// bbd_line_store
// two raw line stores packed in one word, one read and one write per cycle
// ----------------------------------------------------------------------------
module bbd_line_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [bbd_pkg::COL_W-1:0] rd_addr_i,
  output bbd_pkg::line_word_t       rd_data_o,
  input  logic                      wr_en_i,
  input  logic [bbd_pkg::COL_W-1:0] wr_addr_i,
  input  bbd_pkg::line_word_t       wr_data_i
);
  import bbd_pkg::*;

  line_word_t mem [MAX_WIDTH];
  line_word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

  // read and write of one cycle never meet on the same column
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i && wr_en_i) |-> (rd_addr_i != wr_addr_i))
    else $error("line store read and write hit the same column");

endmodule

### src/bbd_interp.sv
// ----------------------------------------------------------------------------
// bbd_interp
// 3x3 window and bilinear color selection, output register
// ----------------------------------------------------------------------------
module bbd_interp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  bbd_pkg::bbd_ctrl_t            ctrl_i,
  input  bbd_pkg::pix_t                 px_i,
  input  bbd_pkg::line_word_t           line_i,
  output logic                          out_valid_o,
  output logic [bbd_pkg::OUT_TDATA_W-1:0] out_data_o,
  output logic                          out_last_o
);
  import bbd_pkg::*;

  pix_t col0_q [3];
  pix_t col1_q [3];

  logic [PIX_W:0]   hor, ver;
  logic [PIX_W+1:0] crs, dia;
  pix_t             ctr, red, green, blue;
  logic             x_odd, y_odd;
  logic [COL_W-1:0] xc;
  logic [ROW_W-1:0] yc;

  logic             out_valid_q;
  logic             out_last_q;
  pix_t             red_q, green_q, blue_q;
  logic [OUT_COL_W-1:0] xc_q;
  logic [ROW_W-1:0] yc_q;

  always_comb begin
    xc    = ctrl_i.col - COL_W'(1);
    yc    = ctrl_i.row - ROW_W'(1);
    x_odd = xc[0];
    y_odd = yc[0];
    ctr   = col1_q[1];
    hor   = ({1'b0, col0_q[1]} + {1'b0, line_i.middle}) >> 1;
    ver   = ({1'b0, col1_q[0]} + {1'b0, col1_q[2]}) >> 1;
    crs   = ({2'b0, col0_q[1]} + {2'b0, line_i.middle} +
             {2'b0, col1_q[0]} + {2'b0, col1_q[2]}) >> 2;
    dia   = ({2'b0, col0_q[0]} + {2'b0, line_i.upper} +
             {2'b0, col0_q[2]} + {2'b0, px_i}) >> 2;
    unique case ({y_odd, x_odd})
      2'b11: begin
        blue = ctr; green = crs[PIX_W-1:0]; red = dia[PIX_W-1:0];
      end
      2'b10: begin
        blue = hor[PIX_W-1:0]; green = ctr; red = ver[PIX_W-1:0];
      end
      2'b01: begin
        blue = ver[PIX_W-1:0]; green = ctr; red = hor[PIX_W-1:0];
      end
      default: begin
        blue = dia[PIX_W-1:0]; green = crs[PIX_W-1:0]; red = ctr;
      end
    endcase
  end

  // window slides by one column per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        col0_q[i] <= '0;
        col1_q[i] <= '0;
      end
    end else if (en_i && ctrl_i.valid) begin
      for (int i = 0; i < 3; i++) begin
        col0_q[i] <= col1_q[i];
      end
      col1_q[0] <= line_i.upper;
      col1_q[1] <= line_i.middle;
      col1_q[2] <= px_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= ctrl_i.valid && ctrl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctrl_i.valid && ctrl_i.emit) begin
      red_q      <= red;
      green_q    <= green;
      blue_q     <= blue;
      xc_q       <= OUT_COL_W'(xc);
      yc_q       <= yc;
      out_last_q <= ctrl_i.done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = OUT_TDATA_W'({yc_q, xc_q, blue_q, green_q, red_q});

  // a held result is not replaced
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !en_i) |=> (out_valid_q && $stable(red_q) && $stable(xc_q)))
    else $error("pending result overwritten");

endmodule

### src/bayer_bilinear_demosaic_unit.sv
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_unit
// bilinear demosaic of an rggb raw stream with two line stores
// ----------------------------------------------------------------------------
// Takes one raw sample per clock and gives at most one rgb pixel per clock,
// unless m_axis_tready holds the output; the sample that completes a pixel's
// 3x3 neighborhood passes the write-back stage and then the output register.
// The rate is set by the line memory, a MAX_WIDTH x 16 array holding both
// previous rows, read once at request and written back once from the write-back
// stage; it needs no clearing pass after reset. Border pixels produce no output.
module bayer_bilinear_demosaic_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_addr_i,
  input  logic [bbd_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // raw_pixel
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // red, green, blue, pixel_column, pixel_row, zero pad
  output logic [bbd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast   // frame_done
);
  import bbd_pkg::*;

  logic [CFG_W-1:0] width_q, height_q;
  logic [CFG_W-1:0] cfg_w_sat, cfg_h_sat;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CMP_W-1:0] col_ext, row_ext, wid_ext, hgt_ext, col_inc, row_inc;
  logic             accept, en, emit, done;
  bbd_ctrl_t        s1_q;
  pix_t             px_q;
  line_word_t       line_rd, line_wr;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // size registers hold the saturated value
  always_comb begin
    if (cfg_wdata_i < CFG_W'(MIN_SIZE)) begin
      cfg_w_sat = CFG_W'(MIN_SIZE);
    end else if (cfg_wdata_i > CFG_W'(MAX_W_CFG)) begin
      cfg_w_sat = CFG_W'(MAX_W_CFG);
    end else begin
      cfg_w_sat = cfg_wdata_i;
    end
    cfg_h_sat = (cfg_wdata_i < CFG_W'(MIN_SIZE)) ? CFG_W'(MIN_SIZE) : cfg_wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1440);
      height_q <= CFG_W'(1080);
    end else if (cfg_we_i) begin
      unique case (reg_index_e'(cfg_addr_i))
        REG_FRAME_WIDTH:  width_q  <= cfg_w_sat;
        REG_FRAME_HEIGHT: height_q <= cfg_h_sat;
        default: ;
      endcase
    end
  end

  always_comb begin
    col_ext = CMP_W'(col_q);
    row_ext = CMP_W'(row_q);
    wid_ext = CMP_W'(width_q);
    hgt_ext = CMP_W'(height_q);
    col_inc = col_ext + CMP_W'(1);
    row_inc = row_ext + CMP_W'(1);
    emit    = (row_ext >= CMP_W'(2)) && (col_ext >= CMP_W'(2)) &&
              (row_ext < hgt_ext) && (col_ext < wid_ext);
    done    = (row_ext == hgt_ext - CMP_W'(1)) && (col_ext == wid_ext - CMP_W'(1));
    if (col_inc >= wid_ext) begin
      col_d = '0;
      row_d = (row_inc >= hgt_ext) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = col_inc[COL_W-1:0];
      row_d = (row_ext >= hgt_ext) ? '0 : row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (en) begin
      s1_q.valid <= accept;
      if (accept) begin
        s1_q.emit <= emit;
        s1_q.done <= done;
        s1_q.col  <= col_q;
        s1_q.row  <= row_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= s_axis_tdata;
    end
  end

  assign line_wr.upper  = line_rd.middle;
  assign line_wr.middle = px_q;

  bbd_line_store u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (line_rd),
    .wr_en_i   (en && s1_q.valid),
    .wr_addr_i (s1_q.col),
    .wr_data_i (line_wr)
  );

  bbd_interp u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctrl_i      (s1_q),
    .px_i        (px_q),
    .line_i      (line_rd),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  a_accept_to_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_q.valid)
    else $error("accepted request missing from write-back stage");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q.valid && !en) |=> (s1_q.valid && $stable(s1_q.col) && $stable(px_q)))
    else $error("stalled write-back stage changed");

endmodule
